@@ sv/led_work_timer_with_flash_core_assert.svh @@
// ----------------------------------------------------------------------------
// LED work timer assertion macros
// Concurrent assertion helpers shared by the LED work timer RTL.
// ----------------------------------------------------------------------------
`ifndef LED_WORK_TIMER_WITH_FLASH_CORE_ASSERT_SVH
`define LED_WORK_TIMER_WITH_FLASH_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define LWT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define LWT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define LWT_ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define LWT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ sv/lwt_pkg.sv @@
// ----------------------------------------------------------------------------
// LED work timer package
// Types, register indexes and field widths of the LED work timer.
// ----------------------------------------------------------------------------
package lwt_pkg;

    localparam int unsigned IN_DATA_W  = 72;
    localparam int unsigned OUT_DATA_W = 40;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        ST_OFF   = 2'd0,
        ST_ON    = 2'd1,
        ST_FLASH = 2'd2
    } led_state_t;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_FLASH = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_UNIT_SECONDS    = 2'd0,
        REG_FLASH_TOGGLES   = 2'd1,
        REG_FLASH_PERIOD_MS = 2'd2,
        REG_NONE            = 2'd3
    } cfg_index_t;

    localparam logic [15:0] UNIT_SECONDS_RESET    = 16'd1800;
    localparam logic [3:0]  FLASH_TOGGLES_RESET   = 4'd8;
    localparam logic [15:0] FLASH_PERIOD_MS_RESET = 16'd100;
    localparam logic [3:0]  TOGGLE_COUNT_MAX      = 4'd15;

endpackage

@@ sv/led_work_timer_with_flash_core.sv @@
// ----------------------------------------------------------------------------
// LED work timer with flash
// Work window timer with an on/off/flash LED state machine, one item per
// cycle on a stream interface while the output is not stalled.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the output side is ready
// and returns exactly one result item for each, in order. An accepted item
// is held in the input register, is evaluated against the timer state
// there, and its result is held in the output register; a stalled output
// only holds the pipeline, no item is lost. Configuration writes take
// effect on the next clock edge; the user must make them only while no
// item is in flight, the block itself does not enforce this.
`include "led_work_timer_with_flash_core_assert.svh"

module led_work_timer_with_flash_core
    import lwt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // now_seconds[31:0], now_millis[63:32], periods[71:64]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // led_level[0], led_state[2:1], window_end[34:3], zero[39:35]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [15:0]          unit_seconds_reg;
    logic [3:0]           flash_toggles_reg;
    logic [15:0]          flash_period_ms_reg;

    logic                 in_valid_reg;
    mode_t                in_mode_reg;
    logic [31:0]          in_sec_reg;
    logic [31:0]          in_ms_reg;
    logic [7:0]           in_periods_reg;

    led_state_t           state_reg, state_next;
    logic                 pin_reg, pin_next;
    logic [31:0]          start_reg, start_next;
    logic [31:0]          work_reg, work_next;
    logic [31:0]          end_reg, end_next;
    logic [3:0]           count_reg, count_next;
    logic [31:0]          last_ms_reg, last_ms_next;

    logic                 out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    logic                 advance;
    logic [23:0]          amount;
    logic [31:0]          gap;
    logic                 gap_ok;
    logic [3:0]           count_step;
    logic [31:0]          work_sum;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_seconds_reg    <= UNIT_SECONDS_RESET;
            flash_toggles_reg   <= FLASH_TOGGLES_RESET;
            flash_period_ms_reg <= FLASH_PERIOD_MS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_UNIT_SECONDS:    unit_seconds_reg    <= cfg_data;
                REG_FLASH_TOGGLES:   flash_toggles_reg   <= cfg_data[3:0];
                REG_FLASH_PERIOD_MS: flash_period_ms_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_mode_reg    <= mode_t'(s_axis_tuser);
            in_sec_reg     <= s_axis_tdata[31:0];
            in_ms_reg      <= s_axis_tdata[63:32];
            in_periods_reg <= s_axis_tdata[71:64];
        end
    end

    assign amount     = {16'd0, in_periods_reg} * {8'd0, unit_seconds_reg};
    assign gap        = in_ms_reg - last_ms_reg;
    assign gap_ok     = gap >= {16'd0, flash_period_ms_reg};
    assign count_step = (gap_ok && count_reg < TOGGLE_COUNT_MAX) ? count_reg + 4'd1 : count_reg;
    assign work_sum   = work_reg + {8'd0, amount};

    always_comb
    begin
        state_next   = state_reg;
        pin_next     = pin_reg;
        start_next   = start_reg;
        work_next    = work_reg;
        end_next     = end_reg;
        count_next   = count_reg;
        last_ms_next = last_ms_reg;
        unique case (in_mode_reg)
            MODE_TICK:
            begin
                if (state_reg == ST_FLASH && work_reg != 32'd0)
                begin
                    if (gap_ok)
                    begin
                        last_ms_next = in_ms_reg;
                        pin_next     = !pin_reg;
                    end
                    count_next = count_step;
                    if (count_step >= flash_toggles_reg)
                    begin
                        state_next   = ST_OFF;
                        start_next   = 32'd0;
                        work_next    = 32'd0;
                        end_next     = 32'd0;
                        count_next   = 4'd0;
                        last_ms_next = 32'd0;
                    end
                end
                else if (state_reg == ST_OFF && end_reg > in_sec_reg)
                begin
                    state_next = ST_ON;
                end
                else if (state_reg == ST_ON && end_reg <= in_sec_reg)
                begin
                    state_next   = ST_OFF;
                    start_next   = 32'd0;
                    work_next    = 32'd0;
                    end_next     = 32'd0;
                    count_next   = 4'd0;
                    last_ms_next = 32'd0;
                end
                if (state_next == ST_ON)
                begin
                    pin_next = 1'b1;
                end
                else if (state_next == ST_OFF)
                begin
                    pin_next = 1'b0;
                end
            end
            MODE_ADD:
            begin
                if (end_reg < in_sec_reg)
                begin
                    start_next = in_sec_reg;
                    work_next  = {8'd0, amount};
                    end_next   = in_sec_reg + {8'd0, amount};
                end
                else
                begin
                    work_next = work_sum;
                    end_next  = start_reg + work_sum;
                end
            end
            MODE_FLASH:
            begin
                state_next = ST_FLASH;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_OFF;
            pin_reg     <= 1'b0;
            start_reg   <= 32'd0;
            work_reg    <= 32'd0;
            end_reg     <= 32'd0;
            count_reg   <= 4'd0;
            last_ms_reg <= 32'd0;
        end
        else if (advance)
        begin
            state_reg   <= state_next;
            pin_reg     <= pin_next;
            start_reg   <= start_next;
            work_reg    <= work_next;
            end_reg     <= end_next;
            count_reg   <= count_next;
            last_ms_reg <= last_ms_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {5'd0, end_next, state_next, pin_next};
        end
    end

    `LWT_ASSERT_IMPL(a_on_lit, clk, rst_n, state_reg == ST_ON, pin_reg)
    `LWT_ASSERT_IMPL(a_off_dark, clk, rst_n, state_reg == ST_OFF, !pin_reg)
    `LWT_ASSERT_IMPL(a_count_flash, clk, rst_n, count_reg != 4'd0, state_reg == ST_FLASH)
    `LWT_ASSERT_NEXT(a_hold_item, clk, rst_n, in_valid_reg && !advance, in_valid_reg)

endmodule

@@ tb/led_work_timer_with_flash_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED work timer with flash testbench
// Drives tick, add, flash and unused items into the stream port under several
// register settings and idle patterns. A scoreboard runs its own copy of the
// timer state machine and checks every result item field by field, in order.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic                  level;
    lwt_pkg::led_state_t   state;
    logic [31:0]           window_end;
} led_result_t;

class led_timer_scoreboard;
    logic [15:0]           unit_s;
    logic [3:0]            toggles_cfg;
    logic [15:0]           period_ms;

    lwt_pkg::led_state_t   state;
    logic                  pin;
    logic [31:0]           win_start;
    logic [31:0]           win_len;
    logic [31:0]           win_end;
    logic [3:0]            toggle_cnt;
    logic [31:0]           last_ms;

    led_result_t           results_due[$];
    int                    errors;

    function new();
        unit_s      = lwt_pkg::UNIT_SECONDS_RESET;
        toggles_cfg = lwt_pkg::FLASH_TOGGLES_RESET;
        period_ms   = lwt_pkg::FLASH_PERIOD_MS_RESET;
        pin         = 1'b0;
        errors      = 0;
        clear_timer();
    endfunction

    function void clear_timer();
        toggle_cnt = 4'd0;
        last_ms    = 32'd0;
        win_start  = 32'd0;
        win_len    = 32'd0;
        win_end    = 32'd0;
        state      = lwt_pkg::ST_OFF;
    endfunction

    function void set_reg(lwt_pkg::cfg_index_t idx, logic [15:0] value);
        case (idx)
            lwt_pkg::REG_UNIT_SECONDS:    unit_s = value;
            lwt_pkg::REG_FLASH_TOGGLES:   toggles_cfg = value[3:0];
            lwt_pkg::REG_FLASH_PERIOD_MS: period_ms = value;
            default: ;
        endcase
    endfunction

    function void tick(logic [31:0] now_s, logic [31:0] now_ms);
        if (state == lwt_pkg::ST_FLASH && win_len != 32'd0) begin
            if ((now_ms - last_ms) >= {16'd0, period_ms}) begin
                last_ms = now_ms;
                if (toggle_cnt < lwt_pkg::TOGGLE_COUNT_MAX)
                    toggle_cnt = toggle_cnt + 4'd1;
                pin = ~pin;
            end
            if (toggle_cnt >= toggles_cfg) begin
                clear_timer();
                pin = 1'b0;
            end
        end else if (state == lwt_pkg::ST_OFF && win_end > now_s) begin
            pin   = 1'b1;
            state = lwt_pkg::ST_ON;
        end else if (state == lwt_pkg::ST_ON && win_end <= now_s) begin
            pin = 1'b0;
            clear_timer();
        end
        if (state == lwt_pkg::ST_ON)
            pin = 1'b1;
        else if (state == lwt_pkg::ST_OFF)
            pin = 1'b0;
    endfunction

    function void add_work(logic [31:0] now_s, logic [7:0] periods);
        logic [31:0] amount;
        amount = {24'd0, periods} * {16'd0, unit_s};
        if (win_end < now_s) begin
            win_start = now_s;
            win_len   = amount;
        end else begin
            win_len = win_len + amount;
        end
        win_end = win_start + win_len;
    endfunction

    function void note_item(lwt_pkg::mode_t mode, logic [31:0] now_s, logic [31:0] now_ms,
                            logic [7:0] periods);
        led_result_t res;
        case (mode)
            lwt_pkg::MODE_TICK:  tick(now_s, now_ms);
            lwt_pkg::MODE_ADD:   add_work(now_s, periods);
            lwt_pkg::MODE_FLASH: state = lwt_pkg::ST_FLASH;
            default: ;
        endcase
        res.level      = pin;
        res.state      = state;
        res.window_end = win_end;
        results_due.push_back(res);
    endfunction

    function void report(string msg);
        if (errors < 100)
            $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endfunction

    function void check_result(logic [lwt_pkg::OUT_DATA_W-1:0] data);
        led_result_t want;
        if (results_due.size() == 0) begin
            report($sformatf("result item %h with no item pending", data));
            return;
        end
        want = results_due.pop_front();
        if (data[0] !== want.level)
            report($sformatf("led_level %b, want %b", data[0], want.level));
        if (data[2:1] !== want.state)
            report($sformatf("led_state %0d, want %0d", data[2:1], want.state));
        if (data[34:3] !== want.window_end)
            report($sformatf("window_end %h, want %h", data[34:3], want.window_end));
    endfunction

    function int pending();
        return results_due.size();
    endfunction
endclass

module led_work_timer_with_flash_core_tb;
    import lwt_pkg::*;

    localparam int IDLE_NONE      = 0;
    localparam int IDLE_SEND      = 1;
    localparam int IDLE_RECV      = 2;
    localparam int IDLE_BOTH      = 3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 180;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    led_timer_scoreboard   sb;
    int                    idle_mode;
    int                    stall_cycles;
    logic [31:0]           wall_s;
    logic [31:0]           wall_ms;

    led_work_timer_with_flash_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic bit sender_idles();
        if (idle_mode == IDLE_SEND)
            return $urandom_range(0, 99) < 76;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(0, 99) < 9;
        return 1'b0;
    endfunction

    function automatic bit receiver_stalls();
        if (idle_mode == IDLE_RECV)
            return $urandom_range(0, 99) < 76;
        if (idle_mode == IDLE_BOTH)
            return $urandom_range(0, 99) < 9;
        return 1'b0;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        m_axis_tready <= !receiver_stalls();
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_item(input mode_t mode, input logic [31:0] now_s,
                             input logic [31:0] now_ms, input logic [7:0] periods);
        while (sender_idles())
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {periods, now_ms, now_s};
        s_axis_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_item(mode, now_s, now_ms, periods);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic send_random();
        int          roll;
        int          step;
        mode_t       mode;
        logic [31:0] now_s;
        logic [31:0] now_ms;
        logic [7:0]  periods;
        roll    = $urandom_range(0, 99);
        periods = 8'($urandom);
        if (roll < 55)
        begin
            mode = MODE_TICK;
            step = $urandom_range(0, 9);
            if (step < 4)
                wall_s += $urandom_range(0, 1);
            else if (step < 7)
                wall_s += $urandom_range(0, 32'(sb.unit_s) * 4 + 8);
            else
                wall_s += $urandom_range(0, 3);
            if ($urandom_range(0, 19) == 0)
                wall_ms = $urandom;
            else
                wall_ms += $urandom_range(0, 32'(sb.period_ms) * 2 + 2);
            now_s  = wall_s;
            now_ms = wall_ms;
        end
        else if (roll < 75)
        begin
            mode   = MODE_ADD;
            wall_s += $urandom_range(0, 2);
            if ($urandom_range(0, 3) != 0)
                periods = 8'($urandom_range(0, 4));
            now_s  = wall_s;
            now_ms = $urandom;
        end
        else if (roll < 85)
        begin
            mode   = MODE_FLASH;
            now_s  = wall_s;
            now_ms = $urandom;
        end
        else if (roll < 90)
        begin
            mode   = MODE_NONE;
            now_s  = $urandom;
            now_ms = $urandom;
        end
        else
        begin
            mode   = mode_t'($urandom_range(0, 3));
            now_s  = $urandom;
            now_ms = $urandom;
        end
        send_item(mode, now_s, now_ms, periods);
    endtask

    task automatic run_phase(input logic [15:0] unit, input logic [3:0] toggles,
                             input logic [15:0] period, input int idle,
                             input logic [31:0] start_s, input bit hold_mid);
        write_reg(REG_UNIT_SECONDS, unit);
        write_reg(REG_FLASH_TOGGLES, {12'd0, toggles});
        write_reg(REG_FLASH_PERIOD_MS, period);
        cfg_we    <= 1'b0;
        idle_mode = idle;
        wall_s    = start_s;
        wall_ms   = $urandom;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (hold_mid && i == PHASE_ITEMS / 2)
                drain();
            send_random();
        end
        drain();
    endtask

    initial
    begin
        sb            = new();
        idle_mode     = IDLE_NONE;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_TICK;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_UNIT_SECONDS;
        cfg_data      <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: on/off window, unused mode, flash run, zero work, wrap
        send_item(MODE_TICK, 32'd0, 32'd0, 8'd0);
        send_item(MODE_ADD, 32'd0, 32'd0, 8'd0);
        send_item(MODE_ADD, 32'd10, 32'd0, 8'd1);
        send_item(MODE_TICK, 32'd10, 32'd0, 8'd0);
        send_item(MODE_TICK, 32'd1809, 32'd0, 8'd0);
        send_item(MODE_TICK, 32'd1810, 32'd0, 8'd0);
        send_item(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_item(MODE_ADD, 32'd100, 32'd0, 8'd255);
        send_item(MODE_TICK, 32'd100, 32'd0, 8'd0);
        send_item(MODE_ADD, 32'd200, 32'd0, 8'd1);
        send_item(MODE_FLASH, 32'd200, 32'd0, 8'd0);
        send_item(MODE_TICK, 32'd200, 32'd50, 8'd0);
        for (int k = 1; k <= 9; k++)
            send_item(MODE_TICK, 32'd200, 32'(100 * k), 8'd0);
        send_item(MODE_FLASH, 32'd0, 32'd0, 8'd0);
        send_item(MODE_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
        send_item(MODE_ADD, 32'hFFFF_FFFF, 32'd0, 8'd255);
        send_item(MODE_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
        drain();

        write_reg(REG_NONE, 16'hFFFF);
        run_phase(16'd5, 4'd3, 16'd10, IDLE_NONE, 32'd0, 1'b0);
        run_phase(16'd1, 4'd15, 16'd65535, IDLE_SEND, $urandom, 1'b0);
        run_phase(16'd65535, 4'd1, 16'd1, IDLE_RECV, 32'd1000, 1'b1);
        run_phase(16'd0, 4'd0, 16'd0, IDLE_BOTH, $urandom, 1'b0);
        run_phase(16'd20, 4'd4, 16'd50, IDLE_NONE, 32'hFFFF_F000, 1'b0);
        run_phase(16'd1800, 4'd8, 16'd100, IDLE_SEND, $urandom, 1'b0);
        run_phase(16'd3, 4'd15, 16'd0, IDLE_RECV, 32'd0, 1'b0);
        run_phase(16'd300, 4'd2, 16'd1000, IDLE_BOTH, $urandom, 1'b0);

        repeat (8) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d result items never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+sv
sv/lwt_pkg.sv
sv/led_work_timer_with_flash_core.sv
tb/led_work_timer_with_flash_core_tb.sv
